@@ hw/rtl/baro_altitude_integrator_assert.svh @@
// assertion macros for the barometric altitude integrator
`ifndef BARO_ALTITUDE_INTEGRATOR_ASSERT_SVH
`define BARO_ALTITUDE_INTEGRATOR_ASSERT_SVH

// same-cycle implication, checked on clk, quiet during reset
`define BAI_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, quiet during reset
`define BAI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/bai_pkg.sv @@
// types, constants and helpers shared by the altitude integrator files
`timescale 1ns / 1ps

package bai_pkg;

  localparam int PRESSURE_W = 21;
  localparam int TEMP_W = 15;
  localparam int GOG_W = 22;
  localparam int ALT_W = 32;
  localparam int LOG_FRAC_BITS = 24;
  localparam int LOG_W = 29;
  localparam int LNMAG_W = 29;
  localparam int SCALE_W = 35;
  localparam int STEP_W = 30;

  localparam logic [31:0] LN2_Q30 = 32'd744261118;
  localparam logic [31:0] MM_PER_M = 32'd1000;
  localparam logic [31:0] ALT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] ALT_MIN = 32'h8000_0000;
  localparam logic [GOG_W-1:0] GOG_RESET = 22'd1918307;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic CFG_GAS_OVER_GRAVITY = 1'b0;
  localparam logic CFG_FAULT_ALTITUDE = 1'b1;

  typedef struct packed {
    logic                    command;
    logic                    sensor_ok;
    logic [PRESSURE_W-1:0]   pressure;
    logic [TEMP_W-1:0]       temperature;
    logic signed [ALT_W-1:0] reference_altitude;
  } in_item_t;

  typedef struct packed {
    logic signed [ALT_W-1:0] altitude;
    logic                    failure;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [PRESSURE_W-1:0] p_new;
    logic [PRESSURE_W-1:0] p_old;
    logic [TEMP_W-1:0]     temperature;
    logic [GOG_W-1:0]      gas_over_gravity;
  } step_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic              rising;
    logic [STEP_W-1:0] step;
  } step_resp_t;

  typedef struct packed {
    logic [4:0]  n;
    logic [31:0] y;
  } norm_t;

  // top-bit index and mantissa shifted up to bit 31, zero taken as one
  function automatic norm_t normalize(input logic [PRESSURE_W-1:0] x);
    logic [31:0] v;
    logic [4:0]  z;
    norm_t       r;
    v = (x == '0) ? 32'd1 : {{(32-PRESSURE_W){1'b0}}, x};
    z = 5'd0;
    if (v[31:16] == '0) begin
      v = {v[15:0], 16'b0};
      z = z + 5'd16;
    end
    if (v[31:24] == '0) begin
      v = {v[23:0], 8'b0};
      z = z + 5'd8;
    end
    if (v[31:28] == '0) begin
      v = {v[27:0], 4'b0};
      z = z + 5'd4;
    end
    if (v[31:30] == '0) begin
      v = {v[29:0], 2'b0};
      z = z + 5'd2;
    end
    if (v[31] == 1'b0) begin
      v = {v[30:0], 1'b0};
      z = z + 5'd1;
    end
    r.n = 5'd31 - z;
    r.y = v;
    return r;
  endfunction

endpackage

@@ hw/rtl/bai_step_unit.sv @@
// altitude step sequencer around one shared 32x32 multiplier
`timescale 1ns / 1ps

module bai_step_unit (
  input  logic                clk,
  input  logic                rst,
  input  bai_pkg::step_req_t  req,
  output bai_pkg::step_resp_t resp
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_LOG  = 10'b00_0000_0010,
    S_DIFF = 10'b00_0000_0100,
    S_MLN  = 10'b00_0000_1000,
    S_MG   = 10'b00_0001_0000,
    S_MT   = 10'b00_0010_0000,
    S_RA   = 10'b00_0100_0000,
    S_MLO  = 10'b00_1000_0000,
    S_MHI  = 10'b01_0000_0000,
    S_SUM  = 10'b10_0000_0000
  } step_state_t;

  localparam logic [4:0] LOG_LAST = 5'(bai_pkg::LOG_FRAC_BITS);

  step_state_t state;
  logic        done;
  logic [4:0]  cnt;
  logic        pass;

  logic [bai_pkg::PRESSURE_W-1:0] p_new;
  logic [bai_pkg::PRESSURE_W-1:0] p_old;
  logic [bai_pkg::TEMP_W-1:0]     temp;
  logic [bai_pkg::GOG_W-1:0]      gog;

  logic [4:0]                        lg_n;
  logic [bai_pkg::LOG_FRAC_BITS-1:0] frac;
  logic [bai_pkg::LOG_W-1:0]         log_old;
  logic [bai_pkg::LOG_W-1:0]         log_new;
  logic [bai_pkg::LOG_W-1:0]         mag;
  logic                              rising;
  logic [bai_pkg::LNMAG_W-1:0]       lnmag;
  logic [bai_pkg::SCALE_W-1:0]       scale;
  logic [63:0]                       acc;
  logic [63:0]                       prod;
  logic [bai_pkg::STEP_W-1:0]        step;

  logic [31:0]   mul_a;
  logic [31:0]   mul_b;
  bai_pkg::norm_t nrm;
  logic [32:0]   y_raw;
  logic          y_bit;
  logic [31:0]   y_next;
  logic [bai_pkg::LOG_W-1:0] log_done;
  logic [59:0]   ln_rnd;
  logic [47:0]   scale_rnd;
  logic [64:0]   sum;

  // squaring feedback: bit is set when the square reached two
  assign nrm      = bai_pkg::normalize(pass ? p_new : p_old);
  assign y_raw    = prod[63:31];
  assign y_bit    = y_raw[32];
  assign y_next   = y_bit ? y_raw[32:1] : y_raw[31:0];
  assign log_done = {lg_n, frac[bai_pkg::LOG_FRAC_BITS-2:0], y_bit};
  assign ln_rnd   = {1'b0, prod[58:0]} + (60'd1 << 29);
  assign scale_rnd = {1'b0, prod[46:0]} + (48'd1 << 11);
  assign sum      = {1'b0, acc} + {1'b0, prod[31:0], 32'b0} + (65'd1 << 33);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LOG: begin
        mul_a = (cnt == 5'd0) ? nrm.y : y_next;
        mul_b = mul_a;
      end
      S_MLN: begin
        mul_a = {3'b0, mag};
        mul_b = bai_pkg::LN2_Q30;
      end
      S_MG: begin
        mul_a = {10'b0, gog};
        mul_b = bai_pkg::MM_PER_M;
      end
      S_MT: begin
        mul_a = prod[31:0];
        mul_b = {17'b0, temp};
      end
      S_MLO: begin
        mul_a = scale[31:0];
        mul_b = {3'b0, lnmag};
      end
      S_MHI: begin
        mul_a = {29'b0, scale[34:32]};
        mul_b = {3'b0, lnmag};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        if (req.start) begin
          p_new <= req.p_new;
          p_old <= req.p_old;
          temp  <= req.temperature;
          gog   <= req.gas_over_gravity;
        end
      end
      S_LOG: begin
        if (cnt == 5'd0) begin
          lg_n <= nrm.n;
          frac <= '0;
        end else begin
          frac <= {frac[bai_pkg::LOG_FRAC_BITS-2:0], y_bit};
          if (cnt == LOG_LAST) begin
            if (pass) begin
              log_new <= log_done;
            end else begin
              log_old <= log_done;
            end
          end
        end
      end
      S_DIFF: begin
        rising <= log_new > log_old;
        mag    <= (log_new > log_old) ? log_new - log_old : log_old - log_new;
      end
      S_MG: lnmag <= ln_rnd[58:30];
      S_RA: scale <= scale_rnd[46:12];
      S_MHI: acc <= prod;
      S_SUM: step <= sum[63:34];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pass  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.start) begin
            state <= S_LOG;
            cnt   <= '0;
            pass  <= 1'b0;
          end
        end
        S_LOG: begin
          if (cnt == LOG_LAST) begin
            cnt <= '0;
            if (pass) begin
              state <= S_DIFF;
            end else begin
              pass <= 1'b1;
            end
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_DIFF: state <= S_MLN;
        S_MLN:  state <= S_MG;
        S_MG:   state <= S_MT;
        S_MT:   state <= S_RA;
        S_RA:   state <= S_MLO;
        S_MLO:  state <= S_MHI;
        S_MHI:  state <= S_SUM;
        S_SUM: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign resp.busy   = (state != S_IDLE) || done;
  assign resp.done   = done;
  assign resp.rising = rising;
  assign resp.step   = step;

endmodule

@@ hw/rtl/baro_altitude_integrator.sv @@
// top level of the barometric altitude integrator
`timescale 1ns / 1ps
`include "baro_altitude_integrator_assert.svh"

// barometric altitude integrator
//
// in channel (in_valid / in_ready / in_data): one item per command. a good
// load item sets the altitude estimate and reference pressure, a sample that
// integrates moves the altitude by the hypsometric step and keeps its pressure.
// out channel (out_valid / out_ready / out_data): exactly one item per input
// item, in order, carrying the altitude estimate and the failure flag.
// cfg port (cfg_write / cfg_index / cfg_data): index 0 gas over gravity,
// index 1 fault altitude; write only while the block is idle.
//
// a sample that integrates waits in the calc state for the step unit; loads
// and fault cases go straight to the wait state. in_ready returns in the
// cycle after the result is loaded, so a new item is accepted only after the
// last result is loaded. the integrating path runs through the step unit:
// two 24-bit logarithms at one squaring per cycle on the shared multiplier,
// then five more passes through it.
// reset restores the config defaults and clears altitude and pressure.
// a stalled receiver holds the result in the output register; the block still
// takes the next item and finishes it, then waits for the register to free.
module baro_altitude_integrator (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bai_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bai_pkg::out_item_t out_data,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_CALC = 3'b010,
    T_WAIT = 3'b100
  } top_state_t;

  top_state_t state;

  // config registers
  logic [bai_pkg::GOG_W-1:0]        gas_over_gravity;
  logic signed [bai_pkg::ALT_W-1:0] fault_altitude;

  // block state and pending result
  logic signed [bai_pkg::ALT_W-1:0] current_altitude;
  logic [bai_pkg::PRESSURE_W-1:0]   last_pressure;
  logic [bai_pkg::PRESSURE_W-1:0]   pend_pressure;
  logic                             fail;

  logic accept;
  logic integrate;
  logic out_load;

  bai_pkg::step_req_t  step_req;
  bai_pkg::step_resp_t step_resp;

  logic [33:0] alt_ext;
  logic [33:0] step_ext;
  logic [33:0] alt_sum;

  assign in_ready  = (state == T_IDLE);
  assign accept    = in_valid && in_ready;
  // only a good sample against a nonzero reference needs the step unit
  assign integrate = accept && (in_data.command == bai_pkg::CMD_SAMPLE) &&
                     in_data.sensor_ok && (last_pressure != '0);
  // output register frees when empty or being taken this cycle
  assign out_load  = (state == T_WAIT) && (!out_valid || out_ready);

  assign step_req.start            = integrate;
  assign step_req.p_new            = in_data.pressure;
  assign step_req.p_old            = last_pressure;
  assign step_req.temperature      = in_data.temperature;
  assign step_req.gas_over_gravity = gas_over_gravity;

  bai_step_unit u_step (
    .clk  (clk),
    .rst  (rst),
    .req  (step_req),
    .resp (step_resp)
  );

  // signed update with two guard bits for saturation
  assign alt_ext  = {{2{current_altitude[31]}}, current_altitude};
  assign step_ext = {4'b0, step_resp.step};
  assign alt_sum  = step_resp.rising ? alt_ext - step_ext : alt_ext + step_ext;

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gas_over_gravity <= bai_pkg::GOG_RESET;
      fault_altitude   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bai_pkg::CFG_GAS_OVER_GRAVITY: gas_over_gravity <= cfg_data[bai_pkg::GOG_W-1:0];
        bai_pkg::CFG_FAULT_ALTITUDE:   fault_altitude   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // new pressure kept until the step lands
  always_ff @(posedge clk) begin
    if (integrate) begin
      pend_pressure <= in_data.pressure;
    end
  end

  // sequencer and block state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= T_IDLE;
      current_altitude <= '0;
      last_pressure    <= '0;
      fail             <= 1'b0;
    end else begin
      case (state)
        T_IDLE: begin
          if (accept) begin
            if (in_data.command == bai_pkg::CMD_LOAD) begin
              // failed load leaves altitude and pressure alone
              if (in_data.sensor_ok) begin
                current_altitude <= in_data.reference_altitude;
                last_pressure    <= in_data.pressure;
                fail             <= 1'b0;
              end else begin
                fail <= 1'b1;
              end
              state <= T_WAIT;
            end else if (!in_data.sensor_ok) begin
              current_altitude <= fault_altitude;
              fail             <= 1'b1;
              state            <= T_WAIT;
            end else if (last_pressure == '0) begin
              // no reference yet: report fault, adopt the new pressure
              current_altitude <= fault_altitude;
              last_pressure    <= in_data.pressure;
              fail             <= 1'b1;
              state            <= T_WAIT;
            end else begin
              state <= T_CALC;
            end
          end
        end
        T_CALC: begin
          if (step_resp.done) begin
            if (alt_sum[33:31] == 3'b000 || alt_sum[33:31] == 3'b111) begin
              current_altitude <= alt_sum[31:0];
            end else if (alt_sum[33]) begin
              current_altitude <= bai_pkg::ALT_MIN;
            end else begin
              current_altitude <= bai_pkg::ALT_MAX;
            end
            last_pressure <= pend_pressure;
            fail          <= 1'b0;
            state         <= T_WAIT;
          end
        end
        T_WAIT: begin
          if (out_load) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.altitude <= current_altitude;
      out_data.failure  <= fail;
    end
  end

  // checks
  `BAI_ASSERT_NEXT(a_start_enters_calc, step_req.start, state == T_CALC, "start without calc")
  `BAI_ASSERT_IMPL(a_done_only_in_calc, step_resp.done, state == T_CALC, "step done out of calc")
  `BAI_ASSERT_IMPL(a_unit_quiet_outside, state != T_CALC, !step_resp.busy || step_req.start,
                   "step unit busy outside calc")

endmodule
